>>> sv/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned HeldDepth  = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFin
  } state_e;

  // pending multi-byte sequence
  typedef struct packed {
    logic [2:0]     seq_len;
    logic [1:0]     held_cnt;
    logic [CpW-1:0] partial;
    logic           broken;
  } dec_t;

  // what one byte step does
  typedef struct packed {
    dec_t           nxt;
    logic           emit;
    logic [CpW-1:0] point;
    logic           hold_we;
    logic [1:0]     hold_idx;
    logic           replay;
    logic [1:0]     replay_cnt;
  } step_t;

endpackage

>>> sv/u8d_step.sv
`timescale 1ns / 1ps

module u8d_step (
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  u8d_pkg::dec_t             dec_i,
  output u8d_pkg::step_t            step_o
);

  logic [2:0] hc_inc;
  logic [2:0] hc_new;

  always_comb begin
    step_o     = '0;
    step_o.nxt = dec_i;
    hc_inc     = {1'b0, dec_i.held_cnt} + 3'd1;
    hc_new     = {1'b0, dec_i.held_cnt};
    if (dec_i.seq_len == 3'd0) begin
      if (!byte_i[7]) begin
        step_o.emit  = 1'b1;
        step_o.point = {{(u8d_pkg::CpW - u8d_pkg::ByteW){1'b0}}, byte_i};
      end else if ((byte_i & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
        step_o.nxt.seq_len  = 3'd2;
        step_o.nxt.partial  = {16'd0, byte_i[4:0]};
        step_o.nxt.held_cnt = 2'd0;
        step_o.nxt.broken   = 1'b0;
      end else if ((byte_i & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
        step_o.nxt.seq_len  = 3'd3;
        step_o.nxt.partial  = {17'd0, byte_i[3:0]};
        step_o.nxt.held_cnt = 2'd0;
        step_o.nxt.broken   = 1'b0;
      end else if ((byte_i & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
        step_o.nxt.seq_len  = 3'd4;
        step_o.nxt.partial  = {18'd0, byte_i[2:0]};
        step_o.nxt.held_cnt = 2'd0;
        step_o.nxt.broken   = 1'b0;
      end
      // stray continuation or 11111xxx: skipped
    end else begin
      if (dec_i.held_cnt != 2'd3) begin
        hc_new          = hc_inc;
        step_o.hold_we  = 1'b1;
        step_o.hold_idx = dec_i.held_cnt;
      end
      step_o.nxt.held_cnt = hc_new[1:0];
      if (!dec_i.broken) begin
        if ((byte_i & u8d_pkg::ContMask) == u8d_pkg::ContCode) begin
          step_o.nxt.partial = {dec_i.partial[u8d_pkg::CpW-7:0], byte_i[5:0]};
        end else begin
          step_o.nxt.broken = 1'b1;
        end
      end
      if ((hc_new + 3'd1) >= dec_i.seq_len) begin
        if (!step_o.nxt.broken) begin
          step_o.emit  = 1'b1;
          step_o.point = step_o.nxt.partial;
        end else begin
          // drop the lead, feed the held bytes back in
          step_o.replay     = 1'b1;
          step_o.replay_cnt = hc_new[1:0];
        end
        step_o.nxt = '0;
      end
    end
  end

endmodule

>>> sv/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps

// UTF-8 to code point decoder. One byte is taken per request; end_of_string_i
// marks the last byte of a string. Each byte runs through a single byte-step
// unit from a 4-entry work queue, one byte per cycle unless a finished point
// must wait for a full output register. A request is loaded, then each byte
// is stepped (the byte itself plus up to six replayed bytes when broken
// sequences nest: three, then two, then one), then the queue is found empty
// and the request is closed out; close-out waits while the output register
// is full. in_ready_o is high only when the sequencer is idle. Code points are
// delivered with run_last_o on the last result of a request; string_done_o
// marks the last result of a string, and a string end that yields no point
// gives a single marker with point_valid_o low.
module utf8_codepoint_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [u8d_pkg::ByteW-1:0] in_byte_i,
  input  logic                      end_of_string_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [u8d_pkg::CpW-1:0]   code_point_o,
  output logic                      point_valid_o,
  output logic                      string_done_o,
  output logic                      run_last_o
);

  u8d_pkg::state_e state_q, state_d;
  u8d_pkg::dec_t   dec_q, dec_d;
  u8d_pkg::step_t  step;

  logic [u8d_pkg::ByteW-1:0] held_q [u8d_pkg::HeldDepth];
  logic [u8d_pkg::ByteW-1:0] qbuf_q [u8d_pkg::QueueDepth];
  logic [u8d_pkg::ByteW-1:0] qbuf_d [u8d_pkg::QueueDepth];
  logic [u8d_pkg::ByteW-1:0] held_ext [u8d_pkg::QueueDepth];
  logic [u8d_pkg::ByteW-1:0] rest [u8d_pkg::QueueDepth];
  logic [2:0] qcnt_q, qcnt_d;
  logic [2:0] qsum;
  logic       end_q, end_d;
  logic       pend_v_q, pend_v_d;
  logic [u8d_pkg::CpW-1:0] pend_cp_q, pend_cp_d;

  logic       out_valid_q, out_valid_d;
  logic [u8d_pkg::CpW-1:0] out_cp_q, out_cp_d;
  logic       out_pv_q, out_pv_d;
  logic       out_sd_q, out_sd_d;
  logic       out_rl_q, out_rl_d;
  logic       slot_free;
  logic       step_go;
  logic [1:0] kidx;

  u8d_step u_step (
    .byte_i (qbuf_q[0]),
    .dec_i  (dec_q),
    .step_o (step)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == u8d_pkg::StIdle);

  always_comb begin
    for (int j = 0; j < u8d_pkg::QueueDepth; j++) begin
      if (j < u8d_pkg::HeldDepth) begin
        held_ext[j] = (step.hold_we && (step.hold_idx == 2'(j))) ? qbuf_q[0] : held_q[j];
      end else begin
        held_ext[j] = '0;
      end
      if (j < u8d_pkg::QueueDepth - 1) begin
        rest[j] = qbuf_q[j+1];
      end else begin
        rest[j] = '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    dec_d       = dec_q;
    qbuf_d      = qbuf_q;
    qcnt_d      = qcnt_q;
    end_d       = end_q;
    pend_v_d    = pend_v_q;
    pend_cp_d   = pend_cp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cp_d    = out_cp_q;
    out_pv_d    = out_pv_q;
    out_sd_d    = out_sd_q;
    out_rl_d    = out_rl_q;
    step_go     = 1'b0;
    qsum        = '0;
    kidx        = '0;
    unique case (state_q)
      u8d_pkg::StIdle: begin
        if (in_valid_i) begin
          qbuf_d[0] = in_byte_i;
          qcnt_d    = 3'd1;
          end_d     = end_of_string_i;
          pend_v_d  = 1'b0;
          state_d   = u8d_pkg::StRun;
        end
      end
      u8d_pkg::StRun: begin
        if (qcnt_q == 3'd0) begin
          state_d = u8d_pkg::StFin;
        end else if (!(step.emit && pend_v_q && !slot_free)) begin
          step_go = 1'b1;
          dec_d   = step.nxt;
          if (step.emit) begin
            // earlier point is not the last of this request
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_cp_d    = pend_cp_q;
              out_pv_d    = 1'b1;
              out_sd_d    = 1'b0;
              out_rl_d    = 1'b0;
            end
            pend_v_d  = 1'b1;
            pend_cp_d = step.point;
          end
          if (step.replay) begin
            for (int j = 0; j < u8d_pkg::QueueDepth; j++) begin
              kidx = 2'(j - int'(step.replay_cnt));
              qbuf_d[j] = (j < int'(step.replay_cnt)) ? held_ext[j] : rest[kidx];
            end
            qsum   = {1'b0, step.replay_cnt} + qcnt_q - 3'd1;
            qcnt_d = (qsum > 3'(u8d_pkg::QueueDepth)) ? 3'(u8d_pkg::QueueDepth) : qsum;
          end else begin
            qbuf_d = rest;
            qcnt_d = qcnt_q - 3'd1;
          end
        end
      end
      u8d_pkg::StFin: begin
        if (pend_v_q || end_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_cp_d    = pend_v_q ? pend_cp_q : '0;
            out_pv_d    = pend_v_q;
            out_sd_d    = end_q;
            out_rl_d    = 1'b1;
            pend_v_d    = 1'b0;
            if (end_q) begin
              dec_d = '0;
            end
            state_d = u8d_pkg::StIdle;
          end
        end else begin
          state_d = u8d_pkg::StIdle;
        end
      end
      default: state_d = u8d_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u8d_pkg::StIdle;
      dec_q       <= '0;
      qcnt_q      <= '0;
      end_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dec_q       <= dec_d;
      qcnt_q      <= qcnt_d;
      end_q       <= end_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qbuf_q    <= qbuf_d;
    pend_cp_q <= pend_cp_d;
    out_cp_q  <= out_cp_d;
    out_pv_q  <= out_pv_d;
    out_sd_q  <= out_sd_d;
    out_rl_q  <= out_rl_d;
    if (step_go && step.hold_we) begin
      held_q[step.hold_idx] <= qbuf_q[0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_cp_q;
  assign point_valid_o = out_pv_q;
  assign string_done_o = out_sd_q;
  assign run_last_o    = out_rl_q;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("decoder ready right after taking a request");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> string_done_o && run_last_o && (code_point_o == '0))
    else $error("end marker malformed");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string_done without run_last");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= 3'(u8d_pkg::QueueDepth))
    else $error("work queue overflow");

endmodule
